// ===== sv/abfs_pkg.sv =====
// Shared constants and types of the A/B feed sequence arbiter.
package abfs_pkg;

    localparam int WINDOW      = 32;
    localparam int WIN_BITS    = $clog2(WINDOW);
    localparam int MAX_RESULTS = 32;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_BITS   = 5;

    localparam logic [1:0] ST_EMIT   = 2'd0;
    localparam logic [1:0] ST_STALE  = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    localparam logic [1:0] REG_PEER_WAIT  = 2'd0;
    localparam logic [1:0] REG_IDLE_FLUSH = 2'd1;
    localparam logic [1:0] REG_START_SEQ  = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [62:0] seq;
        logic        instance_req;
        logic [47:0] event_ms;
        logic [51:0] recv_us;
        logic [15:0] payload_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [62:0] out_seq;
        logic        out_instance;
        logic [47:0] out_event_ms;
        logic [51:0] out_recv_us;
        logic [15:0] out_handle;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0]  pw_limit;
        logic [9:0]  flush_period;
        logic [62:0] seq_base;
    } t_cfg;

endpackage

// ===== sv/abfs_cfg.sv =====
// Configuration register file with its APB-style access port.
module abfs_cfg import abfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg,
    output logic                 o_seq_wr
);

    t_cfg       r_cfg;
    logic       wr;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:3];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pw_limit     <= 8'd5;
            r_cfg.flush_period <= 10'd20;
            r_cfg.seq_base     <= '0;
        end else if (wr) begin
            case (idx)
                REG_PEER_WAIT:  r_cfg.pw_limit     <= pwdata[7:0];
                REG_IDLE_FLUSH: r_cfg.flush_period <= pwdata[9:0];
                REG_START_SEQ:  r_cfg.seq_base     <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PEER_WAIT:  prdata = {56'd0, r_cfg.pw_limit};
            REG_IDLE_FLUSH: prdata = {54'd0, r_cfg.flush_period};
            REG_START_SEQ:  prdata = {1'b0, r_cfg.seq_base};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg    = r_cfg;
    assign o_seq_wr = wr && (idx == REG_START_SEQ);

endmodule

// ===== sv/ab_feed_sequence_arbiter_unit.sv =====
// Top level of the A/B feed sequence arbiter: slot window and request sequencer.
// An update request passes through classify, then slot compare and write.
// A tick request scans up to 32 slots for the first held slot from the next
// expected sequence, runs a release of the held results, checks the idle flush
// and finishes; busy stays high throughout.
// Released results pass through a pending register; each result is on o_res for one
// cycle with o_res_valid, and cannot be held.
module ab_feed_sequence_arbiter_unit import abfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_res_valid,
    output t_res                 o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {S_IDLE, S_ARR, S_UPD, S_SCAN, S_REL, S_FLUSH, S_DONE} t_state;

    t_cfg cfg;
    logic seq_wr;

    abfs_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg), .o_seq_wr(seq_wr)
    );

    t_state              r_state;
    t_req                r_req;
    logic [WINDOW-1:0]   r_valid;
    logic                r_s_inst  [WINDOW];
    logic [47:0]         r_s_ev    [WINDOW];
    logic [51:0]         r_s_rc    [WINDOW];
    logic [15:0]         r_s_h     [WINDOW];
    logic [31:0]         r_s_first [WINDOW];
    logic [62:0]         r_ne;
    logic                r_base;
    logic [31:0]         r_time;
    logic [9:0]          r_idle;
    logic [WIN_BITS-1:0] r_off;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_phase;
    logic                r_have_pend;
    t_res                r_pend;

    logic [62:0]         ne_eff;
    logic [63:0]         diff;
    logic                drop;
    logic [WIN_BITS-1:0] uidx;
    logic [WIN_BITS-1:0] sidx;
    logic [WIN_BITS-1:0] ridx;
    logic [31:0]         age;
    logic                take;
    logic                can_rel;

    assign busy    = (r_state != S_IDLE);
    assign ne_eff  = r_base ? r_ne : r_req.seq;
    assign diff    = {1'b0, r_req.seq} - {1'b0, ne_eff};
    assign drop    = diff[63] || (diff[62:WIN_BITS] != '0);
    assign uidx    = r_req.seq[WIN_BITS-1:0];
    assign sidx    = r_ne[WIN_BITS-1:0] + r_off;
    assign ridx    = r_ne[WIN_BITS-1:0];
    assign age     = r_time - r_s_first[sidx];
    assign can_rel = r_valid[ridx] && (r_cnt < CNT_BITS'(MAX_RESULTS));
    assign take    = (r_req.event_ms > r_s_ev[uidx])
                  || ((r_req.event_ms == r_s_ev[uidx]) && (r_req.recv_us < r_s_rc[uidx]))
                  || ((r_req.event_ms == r_s_ev[uidx]) && (r_req.recv_us == r_s_rc[uidx])
                      && r_s_inst[uidx] && !r_req.instance_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_ne        <= '0;
            r_base      <= 1'b0;
            r_time      <= '0;
            r_idle      <= '0;
            r_off       <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_res_valid <= 1'b0;
                    if (seq_wr) begin
                        r_ne    <= pwdata[62:0];
                        r_base  <= (pwdata[62:0] != '0);
                        r_valid <= '0;
                    end
                    if (start) begin
                        r_req   <= i_req;
                        r_cnt   <= '0;
                        r_off   <= '0;
                        r_phase <= 1'b0;
                        if (i_req.kind == KIND_UPDATE) begin
                            r_state <= S_ARR;
                        end else begin
                            r_time  <= r_time + 32'd1;
                            r_idle  <= r_idle + 10'd1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_ARR: begin
                    r_ne        <= ne_eff;
                    r_base      <= 1'b1;
                    o_res_valid <= drop;
                    if (drop) begin
                        o_res.status        <= diff[63] ? ST_STALE : ST_BEYOND;
                        o_res.out_seq       <= r_req.seq;
                        o_res.out_instance  <= r_req.instance_req;
                        o_res.out_event_ms  <= r_req.event_ms;
                        o_res.out_recv_us   <= r_req.recv_us;
                        o_res.out_handle    <= r_req.payload_handle;
                        o_res.last          <= 1'b1;
                        r_state             <= S_IDLE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    o_res_valid <= 1'b0;
                    if (!r_valid[uidx] || take) begin
                        r_s_inst[uidx] <= r_req.instance_req;
                        r_s_ev[uidx]   <= r_req.event_ms;
                        r_s_rc[uidx]   <= r_req.recv_us;
                        r_s_h[uidx]    <= r_req.payload_handle;
                    end
                    if (!r_valid[uidx]) begin
                        r_s_first[uidx] <= r_time;
                    end
                    r_valid[uidx] <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_SCAN: begin
                    o_res_valid <= 1'b0;
                    if (r_valid[sidx]) begin
                        if (age >= {24'd0, cfg.pw_limit}) begin
                            r_ne    <= r_ne + {{(63-WIN_BITS){1'b0}}, r_off};
                            r_state <= S_REL;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else if (r_off == WIN_BITS'(WINDOW - 1)) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_off <= r_off + WIN_BITS'(1);
                    end
                end
                S_REL: begin
                    o_res_valid <= can_rel && r_have_pend;
                    if (can_rel) begin
                        if (r_have_pend) begin
                            o_res <= r_pend;
                        end
                        r_pend.status       <= ST_EMIT;
                        r_pend.out_seq      <= r_ne;
                        r_pend.out_instance <= r_s_inst[ridx];
                        r_pend.out_event_ms <= r_s_ev[ridx];
                        r_pend.out_recv_us  <= r_s_rc[ridx];
                        r_pend.out_handle   <= r_s_h[ridx];
                        r_pend.last         <= 1'b0;
                        r_have_pend         <= 1'b1;
                        r_valid[ridx]       <= 1'b0;
                        r_ne                <= r_ne + 63'd1;
                        r_cnt               <= r_cnt + CNT_BITS'(1);
                    end else begin
                        r_state <= r_phase ? S_DONE : S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    o_res_valid <= 1'b0;
                    r_phase     <= 1'b1;
                    if (r_idle >= cfg.flush_period) begin
                        r_idle  <= '0;
                        r_state <= S_REL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_res_valid <= r_have_pend;
                    if (r_have_pend) begin
                        o_res <= t_res'({r_pend[$bits(t_res)-1:1], 1'b1});
                    end
                    r_have_pend <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    o_res_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status != ST_EMIT) |-> o_res.last)
        else $error("dropped request result without last");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(MAX_RESULTS))
        else $error("release count beyond limit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_have_pend)
        else $error("pending result left behind when idle");

endmodule
